FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/mham_pkg.sv
// ----------------------------------------------------------------------------
// mham_pkg
// Shared types, codes and constants of the motor health alarm monitor.
// ----------------------------------------------------------------------------
package mham_pkg;

   localparam int SAMPLE_BITS_DEF = 12;
   localparam int TIME_BITS_DEF   = 32;

   localparam int PCT_W       = 7;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;
   localparam int HOLD_W      = 20;
   localparam int INTERVAL_W  = 16;
   localparam int RSP_W       = 48;   // result fields padded to whole bytes
   localparam int QUEUE_DEPTH = 2;

   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   // floor(s/3) == (s*171)>>9 for every sum of three percents
   localparam int SUM_W       = 9;
   localparam int THIRD_W     = 18;
   localparam logic [SUM_W-1:0] THIRD_MUL = 9'd171;
   localparam int THIRD_SHIFT = 9;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_WARN_LEVEL   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FAULT_LEVEL  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ACK_HOLD     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_WARN_BLINK   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FAULT_BLINK  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_WARN_REPORT  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_FAULT_REPORT = 3'd6;

   // register reset values
   localparam logic [PCT_W-1:0]      RST_WARN_LEVEL   = 7'd70;
   localparam logic [PCT_W-1:0]      RST_FAULT_LEVEL  = 7'd84;
   localparam logic [HOLD_W-1:0]     RST_ACK_HOLD     = 20'd30000;
   localparam logic [INTERVAL_W-1:0] RST_WARN_BLINK   = 16'd500;
   localparam logic [INTERVAL_W-1:0] RST_FAULT_BLINK  = 16'd200;
   localparam logic [INTERVAL_W-1:0] RST_WARN_REPORT  = 16'd4000;
   localparam logic [INTERVAL_W-1:0] RST_FAULT_REPORT = 16'd2000;

   // alarm modes
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_WARN   = 2'd1;
   localparam logic [1:0] MODE_ACK    = 2'd2;
   localparam logic [1:0] MODE_FAULT  = 2'd3;

   // buzzer tones
   localparam logic [1:0] TONE_SILENT = 2'd0;
   localparam logic [1:0] TONE_WARN   = 2'd1;
   localparam logic [1:0] TONE_FAULT1 = 2'd2;
   localparam logic [1:0] TONE_FAULTN = 2'd3;

   typedef struct packed {
      logic [INTERVAL_W-1:0] fault_report;
      logic [INTERVAL_W-1:0] warn_report;
      logic [INTERVAL_W-1:0] fault_blink;
      logic [INTERVAL_W-1:0] warn_blink;
      logic [HOLD_W-1:0]     ack_hold;
      logic [PCT_W-1:0]      fault_level;
      logic [PCT_W-1:0]      warn_level;
   } cfg_type;

   // classified tick, front to back
   typedef struct packed {
      logic [2:0]       warn_flags;
      logic [2:0]       fault_flags;
      logic [PCT_W-1:0] health_pct;
      logic [PCT_W-1:0] curr_pct;
      logic [PCT_W-1:0] vib_pct;
      logic [PCT_W-1:0] temp_pct;
      logic             ack_pressed;
   } class_type;

   // result item, lowest field last
   typedef struct packed {
      logic [2:0]       warn_flags;
      logic [2:0]       fault_flags;
      logic [PCT_W-1:0] health_pct;
      logic [PCT_W-1:0] curr_pct;
      logic [PCT_W-1:0] vib_pct;
      logic [PCT_W-1:0] temp_pct;
      logic             report_due;
      logic [1:0]       tone_select;
      logic             amber_lamp;
      logic             blue_lamp;
      logic             red_lamp;
      logic [1:0]       alarm_mode;
   } rsp_type;

endpackage

FILE: rtl/core/mham_front.sv
// ----------------------------------------------------------------------------
// mham_front
// Scales samples to percent, then classifies them against the levels.
// ----------------------------------------------------------------------------
module mham_front #(
   parameter int SAMPLE_BITS = mham_pkg::SAMPLE_BITS_DEF,
   parameter int TIME_BITS   = mham_pkg::TIME_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mham_pkg::cfg_type      cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [SAMPLE_BITS-1:0] temp_raw,
   input  logic [SAMPLE_BITS-1:0] vib_raw,
   input  logic [SAMPLE_BITS-1:0] curr_raw,
   input  logic                   ack_pressed,
   input  logic [TIME_BITS-1:0]   now_ms,
   input  logic                   queue_full,
   output logic                   push,
   output mham_pkg::class_type    push_class,
   output logic [TIME_BITS-1:0]   push_now
);
   import mham_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + PCT_W;
   localparam logic [SAMPLE_BITS:0] FULL_SCALE = (SAMPLE_BITS+1)'((1 << SAMPLE_BITS) - 1);

   logic [SAMPLE_BITS-1:0] raw [3];
   logic [PROD_W-1:0]      prod [3];
   logic [PCT_W-1:0]       quot [3];
   logic [SAMPLE_BITS:0]   rem [3];
   logic [PCT_W-1:0]       pct [3];

   logic                   s1_valid_ff, s1_valid_in;
   logic [PCT_W-1:0]       s1_pct_ff [3];
   logic                   s1_ack_ff;
   logic [TIME_BITS-1:0]   s1_now_ff;

   logic [2:0]             fault_flags, warn_flags;
   logic [SUM_W-1:0]       pct_sum;
   logic [THIRD_W-1:0]     third_prod;
   logic                   take;

   assign raw[0] = temp_raw;
   assign raw[1] = vib_raw;
   assign raw[2] = curr_raw;

   // x/(2^N-1): quotient guess x>>N, remainder stays below twice the divisor
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod[i] = PROD_W'(raw[i]) * PROD_W'(PCT_FULL);
         quot[i] = prod[i][PROD_W-1:SAMPLE_BITS];
         rem[i]  = (SAMPLE_BITS+1)'(prod[i][SAMPLE_BITS-1:0]) + (SAMPLE_BITS+1)'(quot[i]);
         pct[i]  = quot[i] + PCT_W'(rem[i] >= FULL_SCALE);
      end
   end

   assign push        = s1_valid_ff && !queue_full;
   assign in_ready    = !s1_valid_ff || !queue_full;
   assign take        = in_valid && in_ready;
   assign s1_valid_in = take ? 1'b1 : (push ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_pct_ff <= pct;
         s1_ack_ff <= ack_pressed;
         s1_now_ff <= now_ms;
      end
   end

   // classification
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fault_flags[i] = s1_pct_ff[i] >= cfg.fault_level;
         warn_flags[i]  = !fault_flags[i] && (s1_pct_ff[i] >= cfg.warn_level);
      end
   end

   assign pct_sum    = SUM_W'(s1_pct_ff[0]) + SUM_W'(s1_pct_ff[1]) + SUM_W'(s1_pct_ff[2]);
   assign third_prod = THIRD_W'(pct_sum) * THIRD_W'(THIRD_MUL);

   assign push_class.warn_flags  = warn_flags;
   assign push_class.fault_flags = fault_flags;
   assign push_class.health_pct  = PCT_FULL - third_prod[THIRD_SHIFT +: PCT_W];
   assign push_class.temp_pct    = s1_pct_ff[0];
   assign push_class.vib_pct     = s1_pct_ff[1];
   assign push_class.curr_pct    = s1_pct_ff[2];
   assign push_class.ack_pressed = s1_ack_ff;
   assign push_now               = s1_now_ff;

endmodule

FILE: rtl/core/mham_queue.sv
// ----------------------------------------------------------------------------
// mham_queue
// Small FIFO of classified ticks between front and back.
// ----------------------------------------------------------------------------
module mham_queue #(
   parameter int TIME_BITS = mham_pkg::TIME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mham_pkg::class_type  push_class,
   input  logic [TIME_BITS-1:0] push_now,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output mham_pkg::class_type  head_class,
   output logic [TIME_BITS-1:0] head_now
);
   import mham_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   class_type            class_mem [QUEUE_DEPTH];
   logic [TIME_BITS-1:0] now_mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full       = count_ff == DEPTH_CNT;
   assign head_valid = count_ff != '0;
   assign head_class = class_mem[rd_ptr_ff];
   assign head_now   = now_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         class_mem[wr_ptr_ff] <= push_class;
         now_mem[wr_ptr_ff]   <= push_now;
      end
   end

endmodule

FILE: rtl/core/mham_back.sv
// ----------------------------------------------------------------------------
// mham_back
// Alarm mode machine, lamp and tone timers, report pacing, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mham_back #(
   parameter int TIME_BITS = mham_pkg::TIME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mham_pkg::cfg_type    cfg,
   input  logic                 head_valid,
   input  mham_pkg::class_type  head_class,
   input  logic [TIME_BITS-1:0] head_now,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mham_pkg::rsp_type    out_rsp
);
   import mham_pkg::*;

   localparam int CMP_W = (TIME_BITS > HOLD_W) ? TIME_BITS : HOLD_W;

   function automatic logic [CMP_W-1:0] since(input logic [TIME_BITS-1:0] now_t,
                                              input logic [TIME_BITS-1:0] then_t);
      logic [TIME_BITS-1:0] diff;
      diff  = now_t - then_t;
      since = CMP_W'(diff);
   endfunction

   logic [1:0]           mode_ff, mode_in;
   logic                 latch_ff, latch_in;
   logic [TIME_BITS-1:0] ack_start_ff, ack_start_in;
   logic [TIME_BITS-1:0] toggle_ff, toggle_in;
   logic [TIME_BITS-1:0] report_ff, report_in;
   logic                 phase_ff, phase_in;
   logic                 red_ff, red_in;
   logic                 amber_ff, amber_in;
   logic [1:0]           tone_ff, tone_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff;

   logic                 advance, rise, any_fault, multi_fault, blue, report;
   logic [1:0]           mode_a;
   logic                 amber_a;
   logic [1:0]           tone_a;
   logic [CMP_W-1:0]     blink_lim, report_lim;
   logic                 hold_done, blink_due, report_hit;

   assign advance = head_valid && (!rsp_valid_ff || out_ready);
   assign pop     = advance;

   assign any_fault   = head_class.fault_flags != 3'b000;
   assign multi_fault = $countones(head_class.fault_flags) >= 2;

   // acknowledge on a new press while in warning
   assign rise         = head_class.ack_pressed && !latch_ff;
   assign latch_in     = head_class.ack_pressed;
   assign mode_a       = (rise && mode_ff == MODE_WARN) ? MODE_ACK : mode_ff;
   assign ack_start_in = (rise && mode_ff == MODE_WARN) ? head_now : ack_start_ff;
   assign amber_a      = (rise && mode_ff == MODE_WARN) ? 1'b0 : amber_ff;
   assign tone_a       = (rise && mode_ff == MODE_WARN) ? TONE_SILENT : tone_ff;

   assign hold_done = since(head_now, ack_start_in) >= CMP_W'(cfg.ack_hold);

   always_comb begin
      if (any_fault) begin
         mode_in = MODE_FAULT;
      end else if (head_class.warn_flags != 3'b000) begin
         if (mode_a == MODE_ACK) begin
            mode_in = hold_done ? MODE_WARN : MODE_ACK;
         end else begin
            mode_in = MODE_WARN;
         end
      end else begin
         mode_in = MODE_NORMAL;
      end
   end

   assign blink_lim  = (mode_in == MODE_FAULT) ? CMP_W'(cfg.fault_blink) : CMP_W'(cfg.warn_blink);
   assign report_lim = (mode_in == MODE_FAULT) ? CMP_W'(cfg.fault_report)
                                               : CMP_W'(cfg.warn_report);
   assign blink_due  = since(head_now, toggle_ff) >= blink_lim;
   assign report_hit = since(head_now, report_ff) >= report_lim;

   always_comb begin
      toggle_in = toggle_ff;
      report_in = report_ff;
      phase_in  = phase_ff;
      red_in    = 1'b0;
      amber_in  = 1'b0;
      tone_in   = TONE_SILENT;
      blue      = 1'b0;
      report    = 1'b0;
      case (mode_in)
         MODE_WARN: begin
            amber_in = amber_a;
            tone_in  = tone_a;
            if (blink_due) begin
               toggle_in = head_now;
               phase_in  = !phase_ff;
               amber_in  = !phase_ff;
               tone_in   = phase_ff ? TONE_SILENT : TONE_WARN;
            end
            if (report_hit) begin
               report_in = head_now;
               report    = 1'b1;
            end
         end
         MODE_FAULT: begin
            blue    = multi_fault;
            tone_in = multi_fault ? TONE_FAULTN : TONE_FAULT1;
            red_in  = red_ff;
            if (blink_due) begin
               toggle_in = head_now;
               red_in    = !red_ff;
            end
            if (report_hit) begin
               report_in = head_now;
               report    = 1'b1;
            end
         end
         default: begin
            red_in   = 1'b0;
            amber_in = 1'b0;
            tone_in  = TONE_SILENT;
         end
      endcase
   end

   assign rsp_valid_in = advance ? 1'b1 : (out_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         latch_ff     <= 1'b0;
         ack_start_ff <= '0;
         toggle_ff    <= '0;
         report_ff    <= '0;
         phase_ff     <= 1'b0;
         red_ff       <= 1'b0;
         amber_ff     <= 1'b0;
         tone_ff      <= TONE_SILENT;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff      <= mode_in;
            latch_ff     <= latch_in;
            ack_start_ff <= ack_start_in;
            toggle_ff    <= toggle_in;
            report_ff    <= report_in;
            phase_ff     <= phase_in;
            red_ff       <= red_in;
            amber_ff     <= amber_in;
            tone_ff      <= tone_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff.warn_flags  <= head_class.warn_flags;
         rsp_ff.fault_flags <= head_class.fault_flags;
         rsp_ff.health_pct  <= head_class.health_pct;
         rsp_ff.curr_pct    <= head_class.curr_pct;
         rsp_ff.vib_pct     <= head_class.vib_pct;
         rsp_ff.temp_pct    <= head_class.temp_pct;
         rsp_ff.report_due  <= report;
         rsp_ff.tone_select <= tone_in;
         rsp_ff.amber_lamp  <= amber_in;
         rsp_ff.blue_lamp   <= blue;
         rsp_ff.red_lamp    <= red_in;
         rsp_ff.alarm_mode  <= mode_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_rsp   = rsp_ff;

   `ASSERT_IMPLY(a_blue_only_fault, clock, reset, rsp_valid_ff && rsp_ff.blue_lamp, rsp_ff.alarm_mode == MODE_FAULT)
   `ASSERT_IMPLY(a_amber_only_warn, clock, reset, rsp_valid_ff && rsp_ff.amber_lamp, rsp_ff.alarm_mode == MODE_WARN)
   `ASSERT_IMPLY(a_ack_is_quiet, clock, reset, rsp_valid_ff && rsp_ff.alarm_mode == MODE_ACK, rsp_ff.tone_select == TONE_SILENT && !rsp_ff.report_due && !rsp_ff.red_lamp)
   `ASSERT_NEXT(a_mode_holds_idle, clock, reset, !advance, $stable(mode_ff))

endmodule

FILE: rtl/core/motor_health_alarm_monitor.sv
// ----------------------------------------------------------------------------
// motor_health_alarm_monitor
// Scales three sensor samples, flags warnings and faults, runs the alarm.
// ----------------------------------------------------------------------------
// One monitor tick per req_ transfer, one status result per rsp_ transfer, in
// order. The block sustains one tick per clock while rsp_tready stays high:
// a tick is scaled in the front stage, classified on its way into a two-entry
// queue and handled by the alarm machine in the cycle it leaves the queue, so
// its result goes into the result register that drives rsp_. Every tick depends
// on the alarm state left by the one before; the back part's update sets the rate.
// The queue and the result register let the request side keep streaming while
// a result waits on rsp_tready. Thresholds and intervals are written through
// csr_, which is always ready; write them only while no tick is in flight.
// All timer checks use wrapping differences of the now_ms timestamps.
// ----------------------------------------------------------------------------
module motor_health_alarm_monitor #(
   parameter int SAMPLE_BITS = mham_pkg::SAMPLE_BITS_DEF,
   parameter int TIME_BITS   = mham_pkg::TIME_BITS_DEF,
   parameter int REQ_W       = ((3 * SAMPLE_BITS + 1 + TIME_BITS + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // tick input
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // temp_raw, vib_raw, curr_raw, ack_pressed, now_ms, zero pad (from bit 0 up)
   input  logic [REQ_W-1:0]                 req_tdata,
   // status result
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // alarm_mode, red_lamp, blue_lamp, amber_lamp, tone_select, report_due,
   // temp_pct, vib_pct, curr_pct, health_pct, fault_flags, warn_flags, zero pad
   output logic [mham_pkg::RSP_W-1:0]       rsp_tdata,
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mham_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mham_pkg::CSR_DATA_W-1:0]  csr_data
);
   import mham_pkg::*;

   // request field offsets
   localparam int TEMP_LO = 0;
   localparam int VIB_LO  = SAMPLE_BITS;
   localparam int CURR_LO = 2 * SAMPLE_BITS;
   localparam int ACK_LO  = 3 * SAMPLE_BITS;
   localparam int NOW_LO  = 3 * SAMPLE_BITS + 1;

   cfg_type              cfg_ff;
   logic                 push, queue_full, pop, head_valid;
   class_type            push_class, head_class;
   logic [TIME_BITS-1:0] push_now, head_now;
   rsp_type              rsp;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.warn_level   <= RST_WARN_LEVEL;
         cfg_ff.fault_level  <= RST_FAULT_LEVEL;
         cfg_ff.ack_hold     <= RST_ACK_HOLD;
         cfg_ff.warn_blink   <= RST_WARN_BLINK;
         cfg_ff.fault_blink  <= RST_FAULT_BLINK;
         cfg_ff.warn_report  <= RST_WARN_REPORT;
         cfg_ff.fault_report <= RST_FAULT_REPORT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WARN_LEVEL:   cfg_ff.warn_level   <= csr_data[PCT_W-1:0];
            REG_FAULT_LEVEL:  cfg_ff.fault_level  <= csr_data[PCT_W-1:0];
            REG_ACK_HOLD:     cfg_ff.ack_hold     <= csr_data[HOLD_W-1:0];
            REG_WARN_BLINK:   cfg_ff.warn_blink   <= csr_data[INTERVAL_W-1:0];
            REG_FAULT_BLINK:  cfg_ff.fault_blink  <= csr_data[INTERVAL_W-1:0];
            REG_WARN_REPORT:  cfg_ff.warn_report  <= csr_data[INTERVAL_W-1:0];
            REG_FAULT_REPORT: cfg_ff.fault_report <= csr_data[INTERVAL_W-1:0];
            default: ;   // unused index, write dropped
         endcase
      end
   end

   // front: scale and classify
   mham_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .TIME_BITS   (TIME_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .temp_raw    (req_tdata[TEMP_LO +: SAMPLE_BITS]),
      .vib_raw     (req_tdata[VIB_LO +: SAMPLE_BITS]),
      .curr_raw    (req_tdata[CURR_LO +: SAMPLE_BITS]),
      .ack_pressed (req_tdata[ACK_LO]),
      .now_ms      (req_tdata[NOW_LO +: TIME_BITS]),
      .queue_full  (queue_full),
      .push        (push),
      .push_class  (push_class),
      .push_now    (push_now)
   );

   // decoupling queue
   mham_queue #(
      .TIME_BITS (TIME_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_class (push_class),
      .push_now   (push_now),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_class (head_class),
      .head_now   (head_now)
   );

   // back: alarm machine and result register
   mham_back #(
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_class (head_class),
      .head_now   (head_now),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_rsp    (rsp)
   );

   assign rsp_tdata = RSP_W'(rsp);

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the motor health alarm monitor: streams monitor
// ticks in, predicts each status result with an in-bench alarm model and
// compares every result field by field, across several threshold settings.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mham_pkg::*;

   localparam int REQ_W      = ((3 * SAMPLE_BITS_DEF + 1 + TIME_BITS_DEF + 7) / 8) * 8;
   localparam int FULL_SCALE = (1 << SAMPLE_BITS_DEF) - 1;

   // one tick as it sits in req_tdata, lowest field last
   typedef struct packed {
      logic [TIME_BITS_DEF-1:0]   now_ms;
      logic                       ack_pressed;
      logic [SAMPLE_BITS_DEF-1:0] curr_raw;
      logic [SAMPLE_BITS_DEF-1:0] vib_raw;
      logic [SAMPLE_BITS_DEF-1:0] temp_raw;
   } tick_type;

   // ---------------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // ---------------------------------------------------------------------
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   motor_health_alarm_monitor uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // run limit: the slowest legal run needs well under a millisecond
   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------------
   tick_type    tick_q [$];       // ticks waiting to be driven
   rsp_type     status_q [$];     // predicted status results, oldest first
   tick_type    cur_tick;         // tick currently offered on req_
   tick_type    staged;
   int unsigned ticks_queued  = 0;
   int unsigned results_seen  = 0;
   int unsigned mismatch_cnt  = 0;
   logic [31:0] ms_clock      = '0; // timestamp generator
   bit          quiet_run     = 1'b0; // no idling in the closing phase
   bit          send_idle_en  = 1'b0;
   bit          recv_idle_en  = 1'b0;
   int unsigned window_left   = 0;
   int unsigned send_gap      = 0;
   int unsigned recv_stall    = 0;
   bit          long_hold_done = 1'b0;

   // ---------------------------------------------------------------------
   // Alarm model: thresholds plus the machine state carried tick to tick
   // ---------------------------------------------------------------------
   cfg_type     cfg_now;
   logic [1:0]  mode_q        = MODE_NORMAL;
   logic        btn_latch     = 1'b0;
   logic [31:0] ack_start_ms  = '0;
   logic [31:0] toggle_ms     = '0;
   logic [31:0] report_ms     = '0;
   logic        blink_q       = 1'b0;
   logic        red_q         = 1'b0;
   logic        amber_q       = 1'b0;
   logic [1:0]  tone_q        = TONE_SILENT;

   // Advances the alarm model by one tick and returns the status it shows.
   function automatic rsp_type compute_status(tick_type t);
      int unsigned pct [3];
      int unsigned nfault;
      int unsigned sum;
      logic [SAMPLE_BITS_DEF-1:0] raw [3];
      logic [2:0]  fflags;
      logic [2:0]  wflags;
      logic [31:0] now;
      logic [31:0] gap;
      logic        blue;
      logic        report;
      rsp_type     r;
      int          i;
      raw[0] = t.temp_raw;
      raw[1] = t.vib_raw;
      raw[2] = t.curr_raw;
      now    = t.now_ms;
      fflags = '0;
      wflags = '0;
      nfault = 0;
      blue   = 1'b0;
      report = 1'b0;
      // fault wins over warning; reversed levels leave the warning band empty
      for (i = 0; i < 3; i++) begin
         pct[i] = int'(raw[i]) * 100 / FULL_SCALE;
         if (pct[i] >= cfg_now.fault_level) begin
            fflags[i] = 1'b1;
            nfault++;
         end else if (pct[i] >= cfg_now.warn_level) begin
            wflags[i] = 1'b1;
         end
      end
      sum = pct[0] + pct[1] + pct[2];

      // only a fresh press acknowledges, and only out of warning
      if (t.ack_pressed) begin
         if (!btn_latch) begin
            btn_latch = 1'b1;
            if (mode_q == MODE_WARN) begin
               mode_q       = MODE_ACK;
               ack_start_ms = now;
               amber_q      = 1'b0;
               tone_q       = TONE_SILENT;
            end
         end
      end else begin
         btn_latch = 1'b0;
      end

      if (nfault != 0) begin
         mode_q = MODE_FAULT;
      end else if (wflags != 0) begin
         if (mode_q == MODE_ACK) begin
            gap = now - ack_start_ms;
            if (gap >= cfg_now.ack_hold) mode_q = MODE_WARN;
         end else begin
            mode_q = MODE_WARN;
         end
      end else begin
         mode_q = MODE_NORMAL;
      end

      case (mode_q)
         MODE_WARN: begin
            red_q = 1'b0;
            gap = now - toggle_ms;
            // between toggles the tone holds, a leftover fault tone included
            if (gap >= cfg_now.warn_blink) begin
               toggle_ms = now;
               blink_q   = ~blink_q;
               amber_q   = blink_q;
               tone_q    = blink_q ? TONE_WARN : TONE_SILENT;
            end
            gap = now - report_ms;
            if (gap >= cfg_now.warn_report) begin
               report_ms = now;
               report    = 1'b1;
            end
         end
         MODE_FAULT: begin
            amber_q = 1'b0;
            blue    = (nfault >= 2);
            tone_q  = (nfault >= 2) ? TONE_FAULTN : TONE_FAULT1;
            gap = now - toggle_ms;
            if (gap >= cfg_now.fault_blink) begin
               toggle_ms = now;
               red_q     = ~red_q;
            end
            gap = now - report_ms;
            if (gap >= cfg_now.fault_report) begin
               report_ms = now;
               report    = 1'b1;
            end
         end
         default: begin
            red_q   = 1'b0;
            amber_q = 1'b0;
            tone_q  = TONE_SILENT;
         end
      endcase

      r             = '0;
      r.alarm_mode  = mode_q;
      r.red_lamp    = red_q;
      r.blue_lamp   = blue;
      r.amber_lamp  = amber_q;
      r.tone_select = tone_q;
      r.report_due  = report;
      r.temp_pct    = PCT_W'(pct[0]);
      r.vib_pct     = PCT_W'(pct[1]);
      r.curr_pct    = PCT_W'(pct[2]);
      r.health_pct  = PCT_W'(100 - sum / 3);
      r.fault_flags = fflags;
      r.warn_flags  = wflags;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Idle windows: each time the window counter runs out, each side decides
   // whether it may idle, so some stretches run back to back with no gaps at all
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (window_left == 0) begin
         window_left  <= 63;
         send_idle_en <= ($urandom_range(0, 2) != 0);
         recv_idle_en <= ($urandom_range(0, 2) != 0);
      end else begin
         window_left <= window_left - 1;
      end
   end

   // ---------------------------------------------------------------------
   // Tick driver: predicts on every req_ transfer, then offers the next
   // tick or idles for a random stretch counted down in send_gap
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else begin
         if (req_tvalid && req_tready)
            status_q.push_back(compute_status(cur_tick));
         // an offered tick is never withdrawn before its transfer
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap   <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (!quiet_run && send_idle_en && $urandom_range(0, 7) == 0) begin
               send_gap   <= $urandom_range(0, 15);
               req_tvalid <= 1'b0;
            end else if (tick_q.size() != 0) begin
               staged = tick_q.pop_front();
               cur_tick   <= staged;
               req_tdata  <= REQ_W'(staged);
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result side ready: random stalls counted down in recv_stall, plus one long
   // hold-off while plenty of ticks are still queued so the block backs up
   // and has to drop req_tready
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready     <= 1'b0;
         recv_stall     <= 0;
         long_hold_done <= 1'b0;
      end else if (recv_stall != 0) begin
         recv_stall <= recv_stall - 1;
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 250 && tick_q.size() > 50) begin
         long_hold_done <= 1'b1;
         recv_stall     <= 399;
         rsp_tready     <= 1'b0;
      end else if (!quiet_run && recv_idle_en && $urandom_range(0, 5) == 0) begin
         recv_stall <= $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: each rsp_ transfer against the oldest prediction
   // ---------------------------------------------------------------------
   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_cnt++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         got = rsp_tdata[$bits(rsp_type)-1:0];
         if (status_q.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual %h", $time, rsp_tdata);
            mismatch_cnt++;
         end else begin
            want = status_q.pop_front();
            check_field("alarm_mode", want.alarm_mode, got.alarm_mode);
            check_field("red_lamp", want.red_lamp, got.red_lamp);
            check_field("blue_lamp", want.blue_lamp, got.blue_lamp);
            check_field("amber_lamp", want.amber_lamp, got.amber_lamp);
            check_field("tone_select", want.tone_select, got.tone_select);
            check_field("report_due", want.report_due, got.report_due);
            check_field("temp_pct", want.temp_pct, got.temp_pct);
            check_field("vib_pct", want.vib_pct, got.vib_pct);
            check_field("curr_pct", want.curr_pct, got.curr_pct);
            check_field("health_pct", want.health_pct, got.health_pct);
            check_field("fault_flags", want.fault_flags, got.fault_flags);
            check_field("warn_flags", want.warn_flags, got.warn_flags);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_tick(int unsigned t, int unsigned v, int unsigned c, bit ack,
                            logic [31:0] now);
      tick_type k;
      k.temp_raw    = t[SAMPLE_BITS_DEF-1:0];
      k.vib_raw     = v[SAMPLE_BITS_DEF-1:0];
      k.curr_raw    = c[SAMPLE_BITS_DEF-1:0];
      k.ack_pressed = ack;
      k.now_ms      = now;
      tick_q.push_back(k);
      ticks_queued++;
   endtask

   // any raw sample that scales to exactly p percent
   function automatic int unsigned raw_of_pct(int unsigned p);
      int unsigned lo;
      int unsigned hi;
      lo = (p * FULL_SCALE + 99) / 100;
      hi = (p >= 100) ? FULL_SCALE : ((p + 1) * FULL_SCALE + 99) / 100 - 1;
      return $urandom_range(lo, hi);
   endfunction

   // percent for a sensor class under the current levels:
   // 0 below both levels, 1 warning band, 2 fault; falls back to anything
   function automatic int unsigned pct_for(int cls);
      int unsigned wl;
      int unsigned fl;
      int unsigned lo;
      wl = cfg_now.warn_level;
      fl = cfg_now.fault_level;
      lo = (wl < fl) ? wl : fl;
      if (cls == 2 && fl <= 100) return $urandom_range(fl, 100);
      if (cls == 1 && wl < fl && wl <= 100)
         return $urandom_range(wl, (fl > 100) ? 100 : fl - 1);
      if (cls == 0 && lo > 0) return $urandom_range(0, (lo > 101) ? 100 : lo - 1);
      return $urandom_range(0, 100);
   endfunction

   // mostly short steps around the blink and report times, some long ones
   // past the mute time, and with jumpy set arbitrary leaps across the wrap
   function automatic logic [31:0] next_ms(bit jumpy);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (jumpy && r < 30) ms_clock = $urandom();
      else if (r < 70) ms_clock += $urandom_range(0, 700);
      else if (r < 90) ms_clock += $urandom_range(0, 5000);
      else ms_clock += $urandom_range(0, 40000);
      return ms_clock;
   endfunction

   // One burst of related ticks. Most bursts are warning runs with a press
   // and release of the button, or fault runs; the rest mix classes freely,
   // use raw noise or leap through time.
   task automatic add_episode();
      int  kind;
      int  len;
      int  press_at;
      int  press_len;
      int  cls [3];
      int  i;
      int  s;
      bit  ack;
      int unsigned raw [3];
      kind      = $urandom_range(0, 9);
      len       = $urandom_range(3, 20);
      press_at  = $urandom_range(0, len - 1);
      press_len = $urandom_range(1, 3);
      for (s = 0; s < 3; s++) cls[s] = (kind <= 3) ? $urandom_range(0, 1) : 0;
      if (kind <= 3) cls[$urandom_range(0, 2)] = 1;
      else if (kind <= 5) begin
         for (s = 0; s < 3; s++) cls[s] = $urandom_range(0, 2);
         cls[$urandom_range(0, 2)] = 2;
      end
      for (i = 0; i < len; i++) begin
         ack = (i >= press_at && i < press_at + press_len);
         if (kind >= 6) begin
            for (s = 0; s < 3; s++) cls[s] = $urandom_range(0, 2);
            ack = $urandom_range(0, 1);
         end else if ($urandom_range(0, 9) == 0) begin
            cls[$urandom_range(0, 2)] = $urandom_range(0, 2);
         end
         for (s = 0; s < 3; s++)
            raw[s] = (kind == 8) ? $urandom_range(0, FULL_SCALE) : raw_of_pct(pct_for(cls[s]));
         push_tick(raw[0], raw[1], raw[2], ack, next_ms(kind == 9));
      end
   endtask

   task automatic add_random(int unsigned n);
      int unsigned target;
      target = ticks_queued + n;
      while (ticks_queued < target) add_episode();
   endtask

   // waits until every tick has been transferred and answered
   task automatic drain();
      while (tick_q.size() != 0 || req_tvalid || status_q.size() != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);   // write transfer at this edge
      csr_valid <= 1'b0;
      // bits above a register's width are dropped
      case (idx)
         REG_WARN_LEVEL:   cfg_now.warn_level   = val[PCT_W-1:0];
         REG_FAULT_LEVEL:  cfg_now.fault_level  = val[PCT_W-1:0];
         REG_ACK_HOLD:     cfg_now.ack_hold     = val[HOLD_W-1:0];
         REG_WARN_BLINK:   cfg_now.warn_blink   = val[INTERVAL_W-1:0];
         REG_FAULT_BLINK:  cfg_now.fault_blink  = val[INTERVAL_W-1:0];
         REG_WARN_REPORT:  cfg_now.warn_report  = val[INTERVAL_W-1:0];
         REG_FAULT_REPORT: cfg_now.fault_report = val[INTERVAL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(logic [19:0] wl, logic [19:0] fl, logic [19:0] hold,
                                logic [19:0] wb, logic [19:0] fb,
                                logic [19:0] wr, logic [19:0] fr);
      write_reg(REG_WARN_LEVEL, wl);
      write_reg(REG_FAULT_LEVEL, fl);
      write_reg(REG_ACK_HOLD, hold);
      write_reg(REG_WARN_BLINK, wb);
      write_reg(REG_FAULT_BLINK, fb);
      write_reg(REG_WARN_REPORT, wr);
      write_reg(REG_FAULT_REPORT, fr);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      cfg_now.warn_level   = RST_WARN_LEVEL;
      cfg_now.fault_level  = RST_FAULT_LEVEL;
      cfg_now.ack_hold     = RST_ACK_HOLD;
      cfg_now.warn_blink   = RST_WARN_BLINK;
      cfg_now.fault_blink  = RST_FAULT_BLINK;
      cfg_now.warn_report  = RST_WARN_REPORT;
      cfg_now.fault_report = RST_FAULT_REPORT;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed ticks at the reset settings (warn 70, fault 84, mute 30 s)
      push_tick(0, 0, 0, 0, 32'd0);                      // all quiet, floor
      push_tick(4095, 4095, 4095, 0, 32'd100);           // triple fault, full scale
      push_tick(4095, 0, 0, 0, 32'd300);                 // single fault, red toggles
      push_tick(raw_of_pct(83), raw_of_pct(70), raw_of_pct(69), 0, 32'd400);
                                                         // band edges; fault tone held
      push_tick(raw_of_pct(83), 0, 0, 0, 32'd900);       // warning blink on
      push_tick(raw_of_pct(83), 0, 0, 1, 32'd950);       // press: acknowledged
      push_tick(raw_of_pct(75), 0, 0, 1, 32'd1000);      // held press, still muted
      push_tick(raw_of_pct(75), 0, 0, 0, 32'd1100);      // release
      push_tick(raw_of_pct(75), 0, 0, 1, 32'd1200);      // press while muted
      push_tick(raw_of_pct(75), 0, 0, 0, 32'd31000);     // mute expired
      push_tick(0, 0, raw_of_pct(84), 0, 32'd31100);     // fault at the level
      push_tick(0, raw_of_pct(84), raw_of_pct(84), 0, 32'd31150);
      push_tick(0, 0, 0, 0, 32'd31200);                  // back to normal
      push_tick(0, 0, 0, 1, 32'd31300);                  // press in normal
      push_tick(raw_of_pct(72), 0, 0, 0, 32'hFFFF_FF00); // warning near the wrap
      push_tick(raw_of_pct(72), 0, 0, 1, 32'hFFFF_FFF0); // acknowledged at wrap
      push_tick(raw_of_pct(72), 0, 0, 0, 32'h0000_7000); // mute spans the wrap
      push_tick(raw_of_pct(72), 0, 0, 0, 32'h0000_7600); // mute over
      push_tick(4095, 4095, 4095, 1, 32'hFFFF_FFFF);     // time at max
      push_tick(0, 4095, 0, 0, 32'hFFFF_FFFF);           // same timestamp
      push_tick(0, 0, 0, 0, 32'hFFFF_FFFF);
      ms_clock = 32'h0000_8000;
      add_random(130);
      drain();

      // moderate settings
      load_settings(50, 90, 500, 100, 50, 300, 150);
      add_random(130);
      drain();

      // low extremes: everything at least warns, zero intervals
      load_settings(0, 100, 0, 0, 0, 0, 0);
      add_random(120);
      drain();

      // high extremes, with timestamps starting just short of the wrap
      ms_clock = 32'hFFFF_0000;
      load_settings(60, 100, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_random(120);
      drain();

      // reversed levels: no sensor can be in warning
      load_settings(90, 40, 2000, 300, 100, 1000, 500);
      add_random(100);
      drain();

      // random settings with junk above the width of each narrower register
      load_settings(20'($urandom_range(30, 95)) | (20'($urandom()) & 20'hFFF80),
                    20'($urandom_range(40, 100)) | (20'($urandom()) & 20'hFFF80),
                    20'($urandom_range(0, 8000)),
                    20'($urandom_range(0, 1000)) | (20'($urandom()) & 20'hF0000),
                    20'($urandom_range(0, 1000)) | (20'($urandom()) & 20'hF0000),
                    20'($urandom_range(0, 3000)) | (20'($urandom()) & 20'hF0000),
                    20'($urandom_range(0, 3000)) | (20'($urandom()) & 20'hF0000));
      add_random(100);
      drain();

      // closing phase at the reset values, streaming without gaps
      quiet_run = 1'b1;
      load_settings(RST_WARN_LEVEL, RST_FAULT_LEVEL, RST_ACK_HOLD, RST_WARN_BLINK,
                    RST_FAULT_BLINK, RST_WARN_REPORT, RST_FAULT_REPORT);
      add_random(80);
      drain();

      if (mismatch_cnt == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
